// ===== hdl/kcl_pkg.sv =====
// ----------------------------------------------------------------------------
// kcl_pkg
// Types and constants shared by the keypad code lock modules.
// ----------------------------------------------------------------------------
package kcl_pkg;

	localparam logic [7:0] KEY_CLEAR  = 8'h2A;
	localparam logic [7:0] KEY_SUBMIT = 8'h23;
	localparam logic [7:0] KEY_ZERO   = 8'h30;
	localparam logic [7:0] KEY_NINE   = 8'h39;

	localparam int CODE_DIGITS = 4;
	localparam int SHOW_DIGITS = 4;

	localparam int REG_INDEX_W = 3;
	localparam int REG_DATA_W  = 16;

	localparam logic [REG_INDEX_W-1:0] REG_CODE_FIRST  = 3'd0;
	localparam logic [REG_INDEX_W-1:0] REG_CODE_SECOND = 3'd1;
	localparam logic [REG_INDEX_W-1:0] REG_CODE_THIRD  = 3'd2;
	localparam logic [REG_INDEX_W-1:0] REG_CODE_FOURTH = 3'd3;
	localparam logic [REG_INDEX_W-1:0] REG_RESULT_HOLD = 3'd4;

	localparam logic [3:0]  CODE_FIRST_RESET  = 4'd1;
	localparam logic [3:0]  CODE_SECOND_RESET = 4'd2;
	localparam logic [3:0]  CODE_THIRD_RESET  = 4'd3;
	localparam logic [3:0]  CODE_FOURTH_RESET = 4'd4;
	localparam logic [15:0] RESULT_HOLD_RESET = 16'd2000;

	typedef struct packed {
		logic [CODE_DIGITS-1:0][3:0] code_digit;
		logic [15:0]                 result_hold_ms;
	} kcl_cfg_t;

	typedef struct packed {
		logic [7:0]  key_char;
		logic [31:0] now_ms;
	} kcl_item_t;

	typedef struct packed {
		logic        result_mode;
		logic [2:0]  entered_count;
		logic [15:0] entered_digits;
		logic        granted_light;
		logic        denied_light;
	} kcl_result_t;

endpackage

// ===== hdl/kcl_if.sv =====
// ----------------------------------------------------------------------------
// kcl_key_if / kcl_status_if
// Valid/ready channels for key items and lock status results.
// ----------------------------------------------------------------------------
interface kcl_key_if;
	logic        valid;
	logic        ready;
	logic [7:0]  key_char;
	logic [31:0] now_ms;

	modport source (output valid, output key_char, output now_ms, input ready);
	modport sink   (input valid, input key_char, input now_ms, output ready);
endinterface

interface kcl_status_if;
	logic        valid;
	logic        ready;
	logic        result_mode;
	logic [2:0]  entered_count;
	logic [15:0] entered_digits;
	logic        granted_light;
	logic        denied_light;

	modport source (output valid, output result_mode, output entered_count,
		output entered_digits, output granted_light, output denied_light, input ready);
	modport sink   (input valid, input result_mode, input entered_count,
		input entered_digits, input granted_light, input denied_light, output ready);
endinterface

// ===== hdl/keypad_code_lock_core.sv =====
// ----------------------------------------------------------------------------
// keypad_code_lock_core
// Keypad code lock: collects digits, checks them against the access code on
// submit and shows the granted or denied light until cleared or timed out.
//
//   channel   dir  contents                                     per transfer
//   keys      in   key_char, now_ms                             one key item
//   status    out  result_mode, entered_count, entered_digits,  one result
//                  granted_light, denied_light
//   wr_*      in   wr_index, wr_data                            one register
//
// One item per cycle sustained while status is taken; status is valid once
// its key item passes the input register, then update and status register.
// Lock state updates when an item moves from the input register to the
// status register. A stalled status holds both stages; the input register
// still takes an item while the status register is full but draining.
// Reset restores the default code 1-2-3-4, a 2000 ms hold and entry mode.
// ----------------------------------------------------------------------------
module keypad_code_lock_core #(
	parameter int CODE_LENGTH = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	kcl_key_if.sink                         keys,
	kcl_status_if.source                    status,
	input  logic                            wr_en,
	input  logic [kcl_pkg::REG_INDEX_W-1:0] wr_index,
	input  logic [kcl_pkg::REG_DATA_W-1:0]  wr_data
);
	import kcl_pkg::*;

	localparam int CW = $clog2(CODE_LENGTH + 1);

	kcl_cfg_t    cfg;
	kcl_item_t   item_s1;
	logic        valid_s1;
	kcl_result_t result_q;
	logic        valid_q;
	logic        advance;
	logic        load_s1;

	logic                        mode_q;
	logic [CW-1:0]               count_q;
	logic [CODE_LENGTH-1:0][3:0] store_q;
	logic [31:0]                 rtime_q;
	logic                        granted_q;
	logic                        denied_q;

	logic                        mode_n;
	logic [CW-1:0]               count_n;
	logic [CODE_LENGTH-1:0][3:0] store_n;
	logic [31:0]                 rtime_n;
	logic                        granted_n;
	logic                        denied_n;
	kcl_result_t                 result_n;

	kcl_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	kcl_step #(
		.CODE_LENGTH (CODE_LENGTH),
		.CW          (CW)
	) u_step (
		.cfg       (cfg),
		.item      (item_s1),
		.mode      (mode_q),
		.count     (count_q),
		.store     (store_q),
		.rtime     (rtime_q),
		.granted   (granted_q),
		.denied    (denied_q),
		.mode_n    (mode_n),
		.count_n   (count_n),
		.store_n   (store_n),
		.rtime_n   (rtime_n),
		.granted_n (granted_n),
		.denied_n  (denied_n),
		.result    (result_n)
	);

	assign advance    = valid_s1 && (!valid_q || status.ready);
	assign keys.ready = !valid_s1 || advance;
	assign load_s1    = keys.valid && keys.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (keys.ready) begin
			valid_s1 <= keys.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1.key_char <= keys.key_char;
			item_s1.now_ms   <= keys.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (status.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			count_q   <= '0;
			store_q   <= '0;
			rtime_q   <= '0;
			granted_q <= 1'b0;
			denied_q  <= 1'b0;
		end else if (advance) begin
			mode_q    <= mode_n;
			count_q   <= count_n;
			store_q   <= store_n;
			rtime_q   <= rtime_n;
			granted_q <= granted_n;
			denied_q  <= denied_n;
		end
	end

	assign status.valid          = valid_q;
	assign status.result_mode    = result_q.result_mode;
	assign status.entered_count  = result_q.entered_count;
	assign status.entered_digits = result_q.entered_digits;
	assign status.granted_light  = result_q.granted_light;
	assign status.denied_light   = result_q.denied_light;

endmodule

// ===== hdl/kcl_cfg.sv =====
// ----------------------------------------------------------------------------
// kcl_cfg
// Configuration register file: access code digits and result hold time.
// ----------------------------------------------------------------------------
module kcl_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [kcl_pkg::REG_INDEX_W-1:0] wr_index,
	input  logic [kcl_pkg::REG_DATA_W-1:0]  wr_data,
	output kcl_pkg::kcl_cfg_t               cfg
);
	import kcl_pkg::*;

	kcl_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.code_digit[0]  <= CODE_FIRST_RESET;
			cfg_q.code_digit[1]  <= CODE_SECOND_RESET;
			cfg_q.code_digit[2]  <= CODE_THIRD_RESET;
			cfg_q.code_digit[3]  <= CODE_FOURTH_RESET;
			cfg_q.result_hold_ms <= RESULT_HOLD_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CODE_FIRST:  cfg_q.code_digit[0]  <= wr_data[3:0];
				REG_CODE_SECOND: cfg_q.code_digit[1]  <= wr_data[3:0];
				REG_CODE_THIRD:  cfg_q.code_digit[2]  <= wr_data[3:0];
				REG_CODE_FOURTH: cfg_q.code_digit[3]  <= wr_data[3:0];
				REG_RESULT_HOLD: cfg_q.result_hold_ms <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/kcl_step.sv =====
// ----------------------------------------------------------------------------
// kcl_step
// Next-state and status logic for one key item.
// ----------------------------------------------------------------------------
module kcl_step #(
	parameter int CODE_LENGTH = 4,
	parameter int CW          = 3
) (
	input  kcl_pkg::kcl_cfg_t               cfg,
	input  kcl_pkg::kcl_item_t              item,
	input  logic                            mode,
	input  logic [CW-1:0]                   count,
	input  logic [CODE_LENGTH-1:0][3:0]     store,
	input  logic [31:0]                     rtime,
	input  logic                            granted,
	input  logic                            denied,
	output logic                            mode_n,
	output logic [CW-1:0]                   count_n,
	output logic [CODE_LENGTH-1:0][3:0]     store_n,
	output logic [31:0]                     rtime_n,
	output logic                            granted_n,
	output logic                            denied_n,
	output kcl_pkg::kcl_result_t            result
);
	import kcl_pkg::*;

	localparam int SHOWN = (CODE_LENGTH < SHOW_DIGITS) ? CODE_LENGTH : SHOW_DIGITS;

	logic          is_digit;
	logic [3:0]    digit;
	logic [31:0]   elapsed;
	logic          hold_done;
	logic          match;
	logic [15:0]   digits;
	logic [CW+2:0] count_wide;

	assign is_digit  = (item.key_char >= KEY_ZERO) && (item.key_char <= KEY_NINE);
	assign digit     = item.key_char[3:0];
	assign elapsed   = item.now_ms - rtime;
	assign hold_done = elapsed >= {16'd0, cfg.result_hold_ms};

	always_comb begin
		match = (count == CW'(CODE_LENGTH));
		for (int i = 0; i < CODE_LENGTH; i++) begin
			if (i < CODE_DIGITS) begin
				if (store[i] != cfg.code_digit[i]) match = 1'b0;
			end else if (store[i] != 4'd0) begin
				match = 1'b0;
			end
		end
	end

	always_comb begin
		mode_n    = mode;
		count_n   = count;
		store_n   = store;
		rtime_n   = rtime;
		granted_n = granted;
		denied_n  = denied;
		if (mode) begin
			if (item.key_char == KEY_CLEAR || hold_done) begin
				mode_n    = 1'b0;
				count_n   = '0;
				granted_n = 1'b0;
				denied_n  = 1'b0;
			end
		end else if (item.key_char == KEY_CLEAR) begin
			count_n   = '0;
			granted_n = 1'b0;
			denied_n  = 1'b0;
		end else if (item.key_char == KEY_SUBMIT) begin
			if (count != '0) begin
				mode_n    = 1'b1;
				rtime_n   = item.now_ms;
				granted_n = match;
				denied_n  = !match;
			end
		end else if (is_digit) begin
			if (count < CW'(CODE_LENGTH)) begin
				for (int i = 0; i < CODE_LENGTH; i++) begin
					if (count == CW'(i)) store_n[i] = digit;
				end
				count_n = count + CW'(1);
			end
		end
	end

	always_comb begin
		digits = '0;
		for (int i = 0; i < SHOWN; i++) begin
			if (CW'(i) < count_n) digits[15-4*i -: 4] = store_n[i];
		end
	end

	assign count_wide = (CW+3)'(count_n);

	assign result.result_mode    = mode_n;
	assign result.entered_count  = count_wide[2:0];
	assign result.entered_digits = digits;
	assign result.granted_light  = granted_n;
	assign result.denied_light   = denied_n;

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for keypad_code_lock_core. A clocked driver offers key
// items from a queue and a clocked monitor checks every status transfer,
// field by field and in order, against a behavioral model of the lock.
// Directed entry, submit, hold and wraparound cases run first. Random entry
// sessions follow under several access codes and hold times, with random
// idling on both sides in most phases.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import kcl_pkg::*;

	localparam int LONG_HOLD   = 400;
	localparam int PIPE_SLACK  = 6;
	localparam int PHASE_ITEMS = 250;

	logic                   clk;
	logic                   arst_n;
	logic                   wr_en;
	logic [REG_INDEX_W-1:0] wr_index;
	logic [REG_DATA_W-1:0]  wr_data;

	kcl_key_if    key_ch();
	kcl_status_if status_ch();

	keypad_code_lock_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.keys     (key_ch),
		.status   (status_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	logic [3:0]  code_cfg [CODE_DIGITS];
	logic [15:0] hold_cfg;
	logic        lock_mode;
	logic [2:0]  lock_count;
	logic [3:0]  lock_store [CODE_DIGITS];
	logic [31:0] lock_time;
	logic        lock_granted;
	logic        lock_denied;

	kcl_item_t   key_pending[$];
	kcl_result_t status_expected[$];

	logic [31:0] tick_ms;
	int mismatches;
	int queued;
	int transfers;
	int grants;
	int denials;
	int expiries;
	int settings;
	int src_gap;
	int snk_gap;
	bit idle_on;
	bit sink_blocked;
	bit long_hold_go;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic lock_reset();
		code_cfg[0]  = CODE_FIRST_RESET;
		code_cfg[1]  = CODE_SECOND_RESET;
		code_cfg[2]  = CODE_THIRD_RESET;
		code_cfg[3]  = CODE_FOURTH_RESET;
		hold_cfg     = RESULT_HOLD_RESET;
		lock_mode    = 1'b0;
		lock_count   = '0;
		lock_time    = '0;
		lock_granted = 1'b0;
		lock_denied  = 1'b0;
		for (int i = 0; i < CODE_DIGITS; i++)
			lock_store[i] = '0;
	endtask

	task automatic lock_clear();
		lock_mode    = 1'b0;
		lock_count   = '0;
		lock_granted = 1'b0;
		lock_denied  = 1'b0;
	endtask

	task automatic lock_advance(input kcl_item_t it);
		kcl_result_t want;
		logic [15:0] shown;
		logic        hit;
		if (lock_mode) begin
			if (it.key_char == KEY_CLEAR) begin
				lock_clear();
			end else if ((it.now_ms - lock_time) >= 32'(hold_cfg)) begin
				expiries++;
				lock_clear();
			end
		end else if (it.key_char == KEY_CLEAR) begin
			lock_clear();
		end else if (it.key_char == KEY_SUBMIT) begin
			if (lock_count != 0) begin
				hit = (lock_count == CODE_DIGITS);
				for (int i = 0; i < CODE_DIGITS; i++)
					if (lock_store[i] != code_cfg[i])
						hit = 1'b0;
				lock_granted = hit;
				lock_denied  = !hit;
				lock_mode    = 1'b1;
				lock_time    = it.now_ms;
				if (hit)
					grants++;
				else
					denials++;
			end
		end else if (it.key_char >= KEY_ZERO && it.key_char <= KEY_NINE) begin
			if (lock_count < CODE_DIGITS) begin
				lock_store[lock_count] = 4'(it.key_char - KEY_ZERO);
				lock_count = lock_count + 3'd1;
			end
		end
		shown = '0;
		for (int i = 0; i < SHOW_DIGITS; i++)
			if (i < lock_count)
				shown[(SHOW_DIGITS-1-i)*4 +: 4] = lock_store[i];
		want.result_mode    = lock_mode;
		want.entered_count  = lock_count;
		want.entered_digits = shown;
		want.granted_light  = lock_granted;
		want.denied_light   = lock_denied;
		status_expected.push_back(want);
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want) begin
			mismatches++;
			$display("%0t ns: status %s got %0h, expected %0h", $time, field, got, want);
		end
	endtask

	always @(posedge clk) begin : monitor
		kcl_result_t want;
		if (arst_n) begin
			if (status_ch.valid && status_ch.ready) begin
				if (status_expected.size() == 0) begin
					report_mismatch("transfer with nothing pending", 32'd1, 32'd0);
				end else begin
					want = status_expected.pop_front();
					report_mismatch("result_mode", 32'(status_ch.result_mode),
						32'(want.result_mode));
					report_mismatch("entered_count", 32'(status_ch.entered_count),
						32'(want.entered_count));
					report_mismatch("entered_digits", 32'(status_ch.entered_digits),
						32'(want.entered_digits));
					report_mismatch("granted_light", 32'(status_ch.granted_light),
						32'(want.granted_light));
					report_mismatch("denied_light", 32'(status_ch.denied_light),
						32'(want.denied_light));
				end
			end
			if (key_ch.valid && key_ch.ready) begin
				transfers++;
				lock_advance({key_ch.key_char, key_ch.now_ms});
			end
		end
	end

	always @(posedge clk) begin : driver
		kcl_item_t it;
		if (!key_ch.valid || key_ch.ready) begin
			if (src_gap != 0) begin
				src_gap <= src_gap - 1;
				key_ch.valid <= 1'b0;
			end else if (idle_on && key_pending.size() != 0 &&
				$urandom_range(0, 7) == 0) begin
				src_gap <= $urandom_range(0, 10);
				key_ch.valid <= 1'b0;
			end else if (key_pending.size() != 0) begin
				it = key_pending.pop_front();
				key_ch.valid    <= 1'b1;
				key_ch.key_char <= it.key_char;
				key_ch.now_ms   <= it.now_ms;
			end else begin
				key_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : receiver
		if (sink_blocked) begin
			status_ch.ready <= 1'b0;
		end else if (idle_on && snk_gap != 0) begin
			snk_gap <= snk_gap - 1;
			status_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			snk_gap <= $urandom_range(0, 10);
			status_ch.ready <= 1'b0;
		end else begin
			status_ch.ready <= 1'b1;
		end
	end

	initial begin
		wait (long_hold_go);
		@(posedge clk);
		sink_blocked <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		sink_blocked <= 1'b0;
	end

	task automatic push_at(input logic [7:0] key, input logic [31:0] now);
		tick_ms = now;
		key_pending.push_back({key, now});
		queued++;
	endtask

	task automatic push_key(input logic [7:0] key);
		push_at(key, tick_ms + $urandom_range(0, int'(hold_cfg) / 3 + 2));
	endtask

	task automatic push_noise();
		logic [7:0] key;
		key = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 3) == 0)
			push_at(key, $urandom);
		else
			push_key(key);
	endtask

	task automatic queue_session();
		int         n;
		int         pick;
		bit         right;
		logic [3:0] d;
		if ($urandom_range(0, 7) == 0)
			push_key(KEY_CLEAR);
		pick  = $urandom_range(0, 9);
		n     = pick < 6 ? 4 : pick < 8 ? $urandom_range(0, 3) : $urandom_range(5, 7);
		right = $urandom_range(0, 1);
		for (int i = 0; i < n; i++) begin
			if (right && i < CODE_DIGITS && code_cfg[i] <= 9)
				d = code_cfg[i];
			else
				d = 4'($urandom_range(0, 9));
			push_key(KEY_ZERO + d);
			if ($urandom_range(0, 9) == 0)
				push_noise();
		end
		push_key(KEY_SUBMIT);
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(0, 2) == 0)
				push_noise();
			else
				push_key(8'h00);
		end
		if ($urandom_range(0, 1))
			push_key(KEY_CLEAR);
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (transfers != queued || status_expected.size() != 0)
			@(posedge clk);
		repeat (PIPE_SLACK) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_INDEX_W-1:0] idx,
		input logic [REG_DATA_W-1:0] data);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_CODE_FIRST:  code_cfg[0] = data[3:0];
			REG_CODE_SECOND: code_cfg[1] = data[3:0];
			REG_CODE_THIRD:  code_cfg[2] = data[3:0];
			REG_CODE_FOURTH: code_cfg[3] = data[3:0];
			REG_RESULT_HOLD: hold_cfg = data;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [15:0] d0, input logic [15:0] d1,
		input logic [15:0] d2, input logic [15:0] d3, input logic [15:0] hold);
		write_reg(REG_CODE_FIRST, d0);
		write_reg(REG_CODE_SECOND, d1);
		write_reg(REG_CODE_THIRD, d2);
		write_reg(REG_CODE_FOURTH, d3);
		write_reg(REG_RESULT_HOLD, hold);
		settings++;
	endtask

	task automatic random_config();
		set_config(16'($urandom & 32'hFFF0) | 16'($urandom_range(0, 9)),
			16'($urandom & 32'hFFF0) | 16'($urandom_range(0, 9)),
			16'($urandom & 32'hFFF0) | 16'($urandom_range(0, 9)),
			16'($urandom & 32'hFFF0) | 16'($urandom_range(0, 9)),
			$urandom_range(0, 1) ? 16'($urandom_range(0, 4000)) : 16'($urandom));
	endtask

	task automatic run_phase(input bit idle);
		int start;
		start = queued;
		idle_on <= idle;
		while (queued - start < PHASE_ITEMS)
			queue_session();
		wait_idle();
	endtask

	initial begin
		arst_n          = 1'b0;
		wr_en           = 1'b0;
		wr_index        = '0;
		wr_data         = '0;
		key_ch.valid    = 1'b0;
		key_ch.key_char = '0;
		key_ch.now_ms   = '0;
		status_ch.ready = 1'b0;
		tick_ms         = '0;
		settings        = 1;
		lock_reset();
		repeat (10) @(posedge clk);
		arst_n  <= 1'b1;
		idle_on <= 1'b1;
		@(posedge clk);

		push_at(8'h00, 32'd0);
		push_at(KEY_SUBMIT, 32'd5);
		push_at(KEY_ZERO + 8'd1, 32'd10);
		push_at(KEY_ZERO + 8'd2, 32'd11);
		push_at(KEY_ZERO + 8'd3, 32'd12);
		push_at(KEY_ZERO + 8'd4, 32'd13);
		push_at(KEY_ZERO + 8'd5, 32'd14);
		push_at(KEY_SUBMIT, 32'd20);
		push_at(KEY_ZERO + 8'd5, 32'd100);
		push_at(KEY_SUBMIT, 32'd200);
		push_at(8'h00, 32'd2019);
		push_at(8'h00, 32'd2020);
		push_at(KEY_NINE, 32'd2100);
		push_at(KEY_NINE, 32'd2101);
		push_at(KEY_SUBMIT, 32'd2102);
		push_at(8'h41, 32'd2200);
		push_at(KEY_CLEAR, 32'd2300);
		push_at(KEY_ZERO, 32'd2400);
		push_at(KEY_NINE, 32'd2401);
		push_at(KEY_CLEAR, 32'd2402);
		push_at(8'hFF, 32'd2403);
		push_at(KEY_ZERO + 8'd7, 32'hFFFF_FF00);
		push_at(KEY_SUBMIT, 32'hFFFF_FF00);
		push_at(8'h00, 32'h0000_0500);
		push_at(8'h00, 32'h0000_06D0);
		wait_idle();

		set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		run_phase(1'b1);

		tick_ms = 32'hFFFF_0000;
		set_config(16'hABC9, 16'h0009, 16'hFFF9, 16'h0009, 16'hFFFF);
		run_phase(1'b1);

		set_config(16'h0005, 16'hFFFF, 16'h0007, 16'h0000, 16'h0001);
		for (int r = REG_RESULT_HOLD + 1; r < 2 ** REG_INDEX_W; r++)
			write_reg(REG_INDEX_W'(r), REG_DATA_W'($urandom));
		run_phase(1'b1);

		random_config();
		long_hold_go <= 1'b1;
		run_phase(1'b1);

		for (int p = 0; p < 3; p++) begin
			random_config();
			run_phase(p != 1);
		end

		random_config();
		run_phase(1'b0);

		$display("Covered %0d key transfers over %0d register settings: ",
			transfers, settings, "%0d grants, %0d denials, %0d hold timeouts.",
			grants, denials, expiries);
		$display("Included random idling on both channels, a %0d-cycle status ",
			LONG_HOLD, "hold-off and an idle-free last phase.");
		if (mismatches == 0 && status_expected.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
